[hw/rtl/circle_rasterizer_octant_top_assert.svh]
// Assertion macros shared by the circle rasterizer RTL
`ifndef CIRCLE_RASTERIZER_OCTANT_TOP_ASSERT_SVH
`define CIRCLE_RASTERIZER_OCTANT_TOP_ASSERT_SVH

// Checked on every rising aclk edge outside reset
`define CRO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising aclk edge, reset included
`define CRO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/cro_pkg.sv]
// Types and constants shared by the circle rasterizer modules
`timescale 1ns / 1ps

package cro_pkg;

    // Field widths
    localparam int CENTRE_W    = 8;
    localparam int RADIUS_W    = 8;
    localparam int COORD_W     = 9;
    localparam int DEC_W       = 12;
    localparam int POINT_W     = 10;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    // Canvas extent used for the on-canvas flag
    localparam int CANVAS_SIZE = 256;

    // Eight mirrored points per step
    localparam int POINTS_PER_GROUP = 8;
    localparam int POINT_IDX_W      = $clog2(POINTS_PER_GROUP);

    // Group queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command codes carried on s_tuser
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    // One step's worth of work: centre, octant point and end-of-circle mark
    typedef struct packed {
        logic [CENTRE_W-1:0]       centre_row;
        logic [CENTRE_W-1:0]       centre_col;
        logic [COORD_W-1:0]        x;
        logic signed [COORD_W-1:0] y;
        logic                      is_final;
    } group_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hw/rtl/circle_rasterizer_octant_top.sv]
// The first point of a group reaches m_tdata through the group queue, the emitter's
// group register and the output register. Commands are paced by the point emitter,
// one mirrored point per cycle unless m_tready stalls it; a 2-deep group queue lets
// commands run ahead. An advance with no circle active is taken and yields no points.
// Reset (aresetn low, synchronous): no circle active, queue empty, m_tvalid low.
`timescale 1ns / 1ps

module circle_rasterizer_octant_top import cro_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] centre_row, [15:8] centre_col, [23:16] radius
    input  logic [0:0]           s_tuser,   // [0] cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] point_row, [19:10] point_col, rest zero
    output logic [0:0]           m_tuser,   // [0] on_canvas
    output logic                 m_tlast
);

    q_status_t q_status;
    logic      q_push, q_pop;
    group_t    q_wdata, q_rdata;

    // Command front end with step state
    cro_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Group queue
    cro_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    // Point emitter with output register
    cro_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[hw/rtl/cro_fifo.sv]
// Short group queue that decouples the step engine from the point emitter
`timescale 1ns / 1ps
`include "circle_rasterizer_octant_top_assert.svh"

module cro_fifo import cro_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  group_t    wdata,
    input  logic      pop,
    output group_t    rdata,
    output q_status_t status
);

    localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

    group_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    // Status and read port
    always_comb begin
        status.full  = (count_reg == FULL_CNT);
        status.empty = (count_reg == '0);
        rdata        = mem_reg[rd_ptr_reg];
    end

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `CRO_ASSERT(a_no_overflow, !(push && status.full), "push into full group queue")
    `CRO_ASSERT(a_no_underflow, !(pop && status.empty), "pop from empty group queue")
    `CRO_ASSERT(a_count_up, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count did not grow on push")

endmodule

[hw/rtl/cro_front.sv]
// Command front end: accepts transactions and runs the Bresenham circle decision step
`timescale 1ns / 1ps

module cro_front import cro_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] centre_row, [15:8] centre_col, [23:16] radius
    input  logic [0:0]           s_tuser,   // [0] cmd
    input  q_status_t            q_status,
    output logic                 q_push,
    output group_t               q_wdata
);

    logic [COORD_W-1:0]        x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [DEC_W-1:0]   d_reg, d_next;
    logic [CENTRE_W-1:0]       row_reg, row_next;
    logic [CENTRE_W-1:0]       col_reg, col_next;
    logic                      busy_reg, busy_next;

    cmd_t                      cmd;
    logic                      accept;
    logic [CENTRE_W-1:0]       in_row, in_col;
    logic [RADIUS_W-1:0]       in_radius;
    logic signed [DEC_W-1:0]   d_start;
    logic signed [DEC_W-1:0]   x4, y4, d_step;
    logic                      d_le0;
    logic [COORD_W-1:0]        x_adv;
    logic signed [COORD_W-1:0] y_adv;
    logic                      adv_final;

    // Field unpack and handshake
    always_comb begin
        cmd       = cmd_t'(s_tuser[0]);
        in_row    = s_tdata[CENTRE_W-1:0];
        in_col    = s_tdata[2*CENTRE_W-1:CENTRE_W];
        in_radius = s_tdata[2*CENTRE_W+RADIUS_W-1:2*CENTRE_W];
        s_tready  = !q_status.full;
        accept    = s_tvalid && s_tready;
    end

    // One Bresenham circle decision step
    always_comb begin
        d_start = DEC_W'(3) - DEC_W'({in_radius, 1'b0});
        x4      = DEC_W'({x_reg, 2'b00});
        y4      = {{(DEC_W-COORD_W-2){y_reg[COORD_W-1]}}, y_reg, 2'b00};
        d_le0   = d_reg[DEC_W-1] || (d_reg == '0);
        if (d_le0) begin
            d_step = d_reg + x4 + DEC_W'(6);
            y_adv  = y_reg;
        end else begin
            d_step = d_reg + x4 - y4 + DEC_W'(10);
            y_adv  = y_reg - 1'b1;
        end
        x_adv     = x_reg + 1'b1;
        adv_final = $signed({1'b0, x_adv}) > $signed({y_adv[COORD_W-1], y_adv});
    end

    // State update and queue write
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        d_next    = d_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        busy_next = busy_reg;
        q_push    = 1'b0;
        q_wdata   = '{centre_row: in_row, centre_col: in_col, x: '0,
                      y: COORD_W'(in_radius), is_final: 1'b0};
        if (accept) begin
            case (cmd)
                CMD_START: begin
                    x_next    = '0;
                    y_next    = COORD_W'(in_radius);
                    d_next    = d_start;
                    row_next  = in_row;
                    col_next  = in_col;
                    busy_next = 1'b1;
                    q_push    = 1'b1;
                end
                CMD_ADVANCE: begin
                    if (busy_reg) begin
                        x_next    = x_adv;
                        y_next    = y_adv;
                        d_next    = d_step;
                        busy_next = !adv_final;
                        q_push    = 1'b1;
                        q_wdata   = '{centre_row: row_reg, centre_col: col_reg, x: x_adv,
                                      y: y_adv, is_final: adv_final};
                    end
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg    <= '0;
            y_reg    <= '0;
            d_reg    <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            d_reg    <= d_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            busy_reg <= busy_next;
        end
    end

endmodule

[hw/rtl/cro_back.sv]
// Point emitter: expands each queued step into eight mirrored points
`timescale 1ns / 1ps
`include "circle_rasterizer_octant_top_assert.svh"

module cro_back import cro_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_status_t            q_status,
    input  group_t               q_rdata,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] point_row, [19:10] point_col
    output logic [0:0]           m_tuser,   // [0] on_canvas
    output logic                 m_tlast
);

    localparam logic [POINT_IDX_W-1:0] LAST_IDX   = POINT_IDX_W'(POINTS_PER_GROUP - 1);
    localparam logic [POINT_W:0]       CANVAS_LIM = (POINT_W + 1)'(CANVAS_SIZE);

    group_t                 grp_reg, grp_next;
    logic                   active_reg, active_next;
    logic [POINT_IDX_W-1:0] k_reg, k_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic                   load_en;
    logic                   group_done;
    logic signed [POINT_W-1:0] xs, ys, row_mag, col_mag, row_off, col_off;
    logic signed [POINT_W-1:0] pt_row, pt_col;
    logic                   row_in, col_in;

    // Point for the current mirror index
    always_comb begin
        xs      = {1'b0, grp_reg.x};
        ys      = {grp_reg.y[COORD_W-1], grp_reg.y};
        row_mag = k_reg[2] ? ys : xs;
        col_mag = k_reg[2] ? xs : ys;
        row_off = (k_reg[2] ^ k_reg[1]) ? -row_mag : row_mag;
        col_off = (k_reg[2] ^ k_reg[0]) ? -col_mag : col_mag;
        pt_row  = POINT_W'({2'b00, grp_reg.centre_row}) + row_off;
        pt_col  = POINT_W'({2'b00, grp_reg.centre_col}) + col_off;
        row_in  = !pt_row[POINT_W-1] && ({1'b0, pt_row} < CANVAS_LIM);
        col_in  = !pt_col[POINT_W-1] && ({1'b0, pt_col} < CANVAS_LIM);
    end

    // Sequencing over the eight points, next group popped on the last one or when idle
    always_comb begin
        load_en     = !m_tvalid_reg || m_tready;
        group_done  = active_reg && load_en && (k_reg == LAST_IDX);
        q_pop       = !q_status.empty && (!active_reg || group_done);
        grp_next    = q_pop ? q_rdata : grp_reg;
        active_next = active_reg;
        k_next      = k_reg;
        if (q_pop) begin
            active_next = 1'b1;
            k_next      = '0;
        end else begin
            if (group_done) begin
                active_next = 1'b0;
            end
            if (active_reg && load_en) begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load_en) begin
            m_tvalid_next = active_reg;
            m_tdata_next  = M_TDATA_W'({pt_col, pt_row});
            m_tuser_next  = row_in && col_in;
            m_tlast_next  = grp_reg.is_final && (k_reg == LAST_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            active_reg   <= active_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        grp_reg     <= grp_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    `CRO_ASSERT(a_pop_between_groups, q_pop |-> (!active_reg || k_reg == LAST_IDX), "group popped mid-group")
    `CRO_ASSERT(a_hold_on_stall, (active_reg && !load_en) |=> $stable(k_reg) && active_reg, "point index moved while stalled")
    `CRO_ASSERT(a_chain_groups, (group_done && !q_status.empty) |=> (active_reg && k_reg == '0), "next group not started back to back")

endmodule
